// ===== rtl/swsf_pkg.sv =====
`timescale 1ns / 1ps

package swsf_pkg;

	localparam int SEQ_W  = 3;
	localparam int DATA_W = 32;
	localparam int CFG_W  = 3;
	localparam int DUP_W  = 3;

	localparam logic [1:0] CMD_SEND    = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [1:0] TA_NONE    = 2'd0;
	localparam logic [1:0] TA_START   = 2'd1;
	localparam logic [1:0] TA_STOP    = 2'd2;
	localparam logic [1:0] TA_RESTART = 2'd3;

	localparam logic [DUP_W-1:0] DUP_MAX = 3'd7;

	localparam logic REG_WINDOW_LIMIT = 1'b0;
	localparam logic REG_DUP_THRESH   = 1'b1;

	localparam logic [CFG_W-1:0] WINDOW_LIMIT_RST = 3'd4;
	localparam logic [CFG_W-1:0] DUP_THRESH_RST   = 3'd3;

	typedef struct packed {
		logic [1:0]        command;
		logic [DATA_W-1:0] payload;
		logic [SEQ_W-1:0]  seq_field;
		logic              checksum_ok;
	} req_t;

	typedef struct packed {
		logic              accepted;
		logic              packet_valid;
		logic [SEQ_W-1:0]  packet_seq;
		logic [DATA_W-1:0] packet_data;
		logic [1:0]        timer_action;
		logic [SEQ_W-1:0]  timer_seq;
		logic              window_full;
		logic              empty_timeout_error;
		logic              last;
	} rsp_t;

	typedef enum logic [1:0] {
		CLS_SINGLE,
		CLS_POP,
		CLS_RESEND
	} class_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_RESEND
	} state_t;

	typedef struct packed {
		logic accept;
		logic pop;
		logic emit_pop;
		logic emit_resend;
		logic sel_resend;
	} cmd_t;

	typedef struct packed {
		class_t cls;
		logic   pop_done;
		logic   rs_last;
		logic   out_valid;
	} status_t;

endpackage

// ===== rtl/swsf_ctrl.sv =====
`timescale 1ns / 1ps

module swsf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              rsp_ready,
	input  swsf_pkg::status_t status,
	output logic              req_ready,
	output swsf_pkg::cmd_t    cmd
);

	swsf_pkg::state_t state_q, state_d;
	logic out_free;

	assign out_free = !status.out_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swsf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			swsf_pkg::ST_IDLE: begin
				if (req_valid && out_free) begin
					case (status.cls)
						swsf_pkg::CLS_POP:    state_d = swsf_pkg::ST_POP;
						swsf_pkg::CLS_RESEND: state_d = swsf_pkg::ST_RESEND;
						default:              state_d = swsf_pkg::ST_IDLE;
					endcase
				end
			end
			swsf_pkg::ST_POP: begin
				if (status.pop_done && out_free) state_d = swsf_pkg::ST_IDLE;
			end
			swsf_pkg::ST_RESEND: begin
				if (out_free && status.rs_last) state_d = swsf_pkg::ST_IDLE;
			end
			default: state_d = swsf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready       = (state_q == swsf_pkg::ST_IDLE) && out_free;
		cmd.accept      = req_ready && req_valid;
		cmd.pop         = (state_q == swsf_pkg::ST_POP) && !status.pop_done;
		cmd.emit_pop    = (state_q == swsf_pkg::ST_POP) && status.pop_done && out_free;
		cmd.emit_resend = (state_q == swsf_pkg::ST_RESEND) && out_free;
		cmd.sel_resend  = (state_q == swsf_pkg::ST_RESEND);
	end

endmodule

// ===== rtl/swsf_dp.sv =====
`timescale 1ns / 1ps

module swsf_dp #(
	parameter int WINDOW_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swsf_pkg::req_t     req,
	input  swsf_pkg::cmd_t     cmd,
	output swsf_pkg::status_t  status,
	output swsf_pkg::rsp_t     rsp,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata
);

	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int OW = $clog2(WINDOW_DEPTH + 1);
	localparam int TW = OW + 1;
	localparam int LW = (OW > swsf_pkg::CFG_W) ? OW : swsf_pkg::CFG_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_DEPTH - 1);

	localparam int SW = swsf_pkg::SEQ_W;
	localparam int DW = swsf_pkg::DATA_W;
	localparam int CW = swsf_pkg::CFG_W;
	localparam int UW = swsf_pkg::DUP_W;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
		wrap_inc = (idx == LAST_IDX) ? '0 : idx + IW'(1);
	endfunction

	logic [SW-1:0] seq_store_q  [WINDOW_DEPTH];
	logic [DW-1:0] data_store_q [WINDOW_DEPTH];

	logic [IW-1:0] head_q, head_d;
	logic [OW-1:0] occ_q, occ_d;
	logic [SW-1:0] base_q, base_d;
	logic [SW-1:0] next_q, next_d;
	logic [UW-1:0] dup_q, dup_d;
	logic [SW-1:0] old_base_q, old_base_d;
	logic [IW-1:0] rs_ptr_q, rs_ptr_d;
	logic [OW-1:0] rs_cnt_q, rs_cnt_d;
	logic [CW-1:0] limit_q, thr_q;
	logic          out_valid_q, out_valid_d;
	swsf_pkg::rsp_t out_q, out_d;

	logic [IW-1:0] rd_addr;
	logic [SW-1:0] front_seq;
	logic [DW-1:0] front_data;
	logic [TW-1:0] tail_sum;
	logic [IW-1:0] tail_idx;
	logic [LW-1:0] lim_ext;
	logic [OW-1:0] eff_lim;
	logic [CW-1:0] thr_eff;
	logic [UW-1:0] dup_inc;
	logic          full_now;
	logic          wr_en;

	swsf_pkg::class_t a_cls;
	swsf_pkg::rsp_t   a_res;
	logic [OW-1:0]    a_occ;
	logic [SW-1:0]    a_next, a_base, a_old_base;
	logic [UW-1:0]    a_dup;
	logic             a_wr;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= swsf_pkg::WINDOW_LIMIT_RST;
			thr_q   <= swsf_pkg::DUP_THRESH_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == swsf_pkg::REG_WINDOW_LIMIT) limit_q <= pwdata[CW-1:0];
			else                                        thr_q   <= pwdata[CW-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == swsf_pkg::REG_WINDOW_LIMIT) prdata = {{(32-CW){1'b0}}, limit_q};
		else                                        prdata = {{(32-CW){1'b0}}, thr_q};
	end

	always_comb begin
		lim_ext = LW'(limit_q);
		if (lim_ext == '0)                     eff_lim = OW'(1);
		else if (lim_ext > LW'(WINDOW_DEPTH)) eff_lim = OW'(WINDOW_DEPTH);
		else                                   eff_lim = lim_ext[OW-1:0];
		thr_eff  = (thr_q == '0) ? CW'(1) : thr_q;
		dup_inc  = (dup_q < swsf_pkg::DUP_MAX) ? dup_q + UW'(1) : dup_q;
		full_now = (occ_q >= eff_lim) || (occ_q >= OW'(WINDOW_DEPTH));
		tail_sum = TW'(head_q) + TW'(occ_q);
		if (tail_sum >= TW'(WINDOW_DEPTH)) tail_sum = tail_sum - TW'(WINDOW_DEPTH);
		tail_idx = tail_sum[IW-1:0];
	end

	assign rd_addr    = cmd.sel_resend ? rs_ptr_q : head_q;
	assign front_seq  = seq_store_q[rd_addr];
	assign front_data = data_store_q[rd_addr];

	// decode of the offered request beat
	always_comb begin
		a_cls      = swsf_pkg::CLS_SINGLE;
		a_res      = '0;
		a_occ      = occ_q;
		a_next     = next_q;
		a_base     = base_q;
		a_old_base = old_base_q;
		a_dup      = dup_q;
		a_wr       = 1'b0;
		case (req.command)
			swsf_pkg::CMD_SEND: begin
				if (!full_now) begin
					a_wr               = 1'b1;
					a_occ              = occ_q + OW'(1);
					a_next             = next_q + SW'(1);
					a_res.accepted     = 1'b1;
					a_res.packet_valid = 1'b1;
					a_res.packet_seq   = next_q;
					a_res.packet_data  = req.payload;
					if (occ_q == '0) begin
						a_res.timer_action = swsf_pkg::TA_START;
						a_res.timer_seq    = next_q;
					end
				end
			end
			swsf_pkg::CMD_ACK: begin
				if (req.checksum_ok) begin
					if (req.seq_field != base_q) begin
						a_dup      = '0;
						a_old_base = base_q;
						a_base     = req.seq_field;
						a_cls      = swsf_pkg::CLS_POP;
					end else if (dup_inc >= thr_eff) begin
						a_dup = '0;
						if (occ_q == '0) begin
							a_res.timer_action = swsf_pkg::TA_RESTART;
							a_res.timer_seq    = base_q;
						end else begin
							a_cls = swsf_pkg::CLS_RESEND;
						end
					end else begin
						a_dup = dup_inc;
					end
				end
			end
			swsf_pkg::CMD_TIMEOUT: begin
				if (occ_q == '0) begin
					a_res.empty_timeout_error = 1'b1;
				end else begin
					a_res.packet_valid = 1'b1;
					a_res.packet_seq   = front_seq;
					a_res.packet_data  = front_data;
					a_res.timer_action = swsf_pkg::TA_RESTART;
					a_res.timer_seq    = req.seq_field;
				end
			end
			default: ;
		endcase
		a_res.window_full = (a_occ >= eff_lim);
		a_res.last        = 1'b1;
	end

	assign status.cls       = a_cls;
	assign status.pop_done  = (occ_q == '0) || (front_seq == base_q);
	assign status.rs_last   = (rs_cnt_q + OW'(1)) == occ_q;
	assign status.out_valid = out_valid_q;

	always_comb begin
		head_d      = head_q;
		occ_d       = occ_q;
		base_d      = base_q;
		next_d      = next_q;
		dup_d       = dup_q;
		old_base_d  = old_base_q;
		rs_ptr_d    = rs_ptr_q;
		rs_cnt_d    = rs_cnt_q;
		wr_en       = 1'b0;
		out_d       = out_q;
		out_valid_d = out_valid_q;
		if (out_valid_q && rsp_ready) out_valid_d = 1'b0;
		if (cmd.accept) begin
			occ_d      = a_occ;
			next_d     = a_next;
			base_d     = a_base;
			old_base_d = a_old_base;
			dup_d      = a_dup;
			wr_en      = a_wr;
			rs_ptr_d   = head_q;
			rs_cnt_d   = '0;
			if (a_cls == swsf_pkg::CLS_SINGLE) begin
				out_d       = a_res;
				out_valid_d = 1'b1;
			end
		end
		if (cmd.pop) begin
			head_d = wrap_inc(head_q);
			occ_d  = occ_q - OW'(1);
		end
		if (cmd.emit_pop) begin
			out_d             = '0;
			out_d.window_full = (occ_q >= eff_lim);
			out_d.last        = 1'b1;
			if (occ_q != '0) begin
				out_d.timer_action = swsf_pkg::TA_RESTART;
				out_d.timer_seq    = base_q;
			end else begin
				out_d.timer_action = swsf_pkg::TA_STOP;
				out_d.timer_seq    = old_base_q;
			end
			out_valid_d = 1'b1;
		end
		if (cmd.emit_resend) begin
			out_d              = '0;
			out_d.packet_valid = 1'b1;
			out_d.packet_seq   = front_seq;
			out_d.packet_data  = front_data;
			out_d.window_full  = (occ_q >= eff_lim);
			out_d.last         = status.rs_last;
			if (rs_cnt_q == '0) begin
				out_d.timer_action = swsf_pkg::TA_RESTART;
				out_d.timer_seq    = base_q;
			end
			rs_ptr_d    = wrap_inc(rs_ptr_q);
			rs_cnt_d    = rs_cnt_q + OW'(1);
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			occ_q       <= '0;
			base_q      <= '0;
			next_q      <= '0;
			dup_q       <= '0;
			old_base_q  <= '0;
			rs_ptr_q    <= '0;
			rs_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			head_q      <= head_d;
			occ_q       <= occ_d;
			base_q      <= base_d;
			next_q      <= next_d;
			dup_q       <= dup_d;
			old_base_q  <= old_base_d;
			rs_ptr_q    <= rs_ptr_d;
			rs_cnt_q    <= rs_cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= out_d;
		if (wr_en) begin
			seq_store_q[tail_idx]  <= next_q;
			data_store_q[tail_idx] <= req.payload;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

endmodule

// ===== rtl/sliding_window_sender_fast_retx.sv =====
`timescale 1ns / 1ps

// Sliding-window sender with fast retransmit, sequence numbers modulo 8. A request beat
// carries a send, an ack or a timeout command and produces one to WINDOW_DEPTH response
// beats, the final one marked by last. A send, a bad ack, a repeated ack below threshold
// and a timeout produce one beat; a new ack walks the stored packets one per cycle to pop
// them and then emits its beat, and a fast retransmit sends the whole window one beat per
// cycle while the receiver is ready. No new request is taken until the walk for the last
// one is done, so the single-entry walk over the window store sets the rate when the
// window is busy. The response register lets a new request be taken in the cycle its
// last beat leaves. window_limit (0x0) and dup_ack_threshold (0x4) are to be written
// over the APB port only while idle; the block itself does not enforce this.

module sliding_window_sender_fast_retx #(
	parameter int WINDOW_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  swsf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output swsf_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	swsf_pkg::cmd_t    cmd;
	swsf_pkg::status_t status;

	assign pready = 1'b1;

	swsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	swsf_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata)
	);

endmodule

// ===== dv/window_sender_checker.sv =====
`timescale 1ns / 1ps

module window_sender_checker
	import swsf_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  rsp_t             rsp,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	input  logic             pready,
	output int               mismatches,
	output int               outstanding,
	output logic [SEQ_W-1:0] base_seq_now,
	output logic [SEQ_W-1:0] next_seq_now
);

	logic [SEQ_W-1:0]  seq_store [DEPTH];
	logic [DATA_W-1:0] data_store [DEPTH];
	int unsigned       head;
	int unsigned       occ;
	logic [SEQ_W-1:0]  base_sq;
	logic [SEQ_W-1:0]  next_sq;
	int unsigned       dup_cnt;
	logic [CFG_W-1:0]  limit_reg;
	logic [DUP_W-1:0]  thresh_reg;
	int                err_cnt;
	rsp_t              expected_beats [$];
	rsp_t              want;

	function automatic int unsigned window_cap();
		if (limit_reg == 0)
			return 1;
		if (limit_reg > DEPTH)
			return DEPTH;
		return limit_reg;
	endfunction

	function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	function automatic void predict_beats(req_t r);
		rsp_t             b;
		rsp_t             beats [$];
		logic [SEQ_W-1:0] old_base;
		int unsigned      slot;
		int unsigned      thr;
		b = '0;
		case (r.command)
		CMD_SEND: begin
			if (occ < window_cap()) begin
				slot = (head + occ) % DEPTH;
				seq_store[slot] = next_sq;
				data_store[slot] = r.payload;
				b.accepted = 1'b1;
				b.packet_valid = 1'b1;
				b.packet_seq = next_sq;
				b.packet_data = r.payload;
				if (occ == 0) begin
					b.timer_action = TA_START;
					b.timer_seq = next_sq;
				end
				occ++;
				next_sq = next_sq + 1'b1;
			end
			beats.push_back(b);
		end
		CMD_ACK: begin
			if (!r.checksum_ok) begin
				beats.push_back(b);
			end else if (r.seq_field != base_sq) begin
				old_base = base_sq;
				dup_cnt = 0;
				base_sq = r.seq_field;
				while (occ > 0 && seq_store[head] != base_sq) begin
					head = (head + 1) % DEPTH;
					occ--;
				end
				if (occ > 0) begin
					b.timer_action = TA_RESTART;
					b.timer_seq = base_sq;
				end else begin
					b.timer_action = TA_STOP;
					b.timer_seq = old_base;
				end
				beats.push_back(b);
			end else begin
				thr = (thresh_reg == 0) ? 1 : thresh_reg;
				if (dup_cnt < DUP_MAX)
					dup_cnt++;
				if (dup_cnt >= thr) begin
					if (occ == 0) begin
						b.timer_action = TA_RESTART;
						b.timer_seq = base_sq;
						beats.push_back(b);
					end else begin
						for (int k = 0; k < occ; k++) begin
							b = '0;
							slot = (head + k) % DEPTH;
							b.packet_valid = 1'b1;
							b.packet_seq = seq_store[slot];
							b.packet_data = data_store[slot];
							if (k == 0) begin
								b.timer_action = TA_RESTART;
								b.timer_seq = base_sq;
							end
							beats.push_back(b);
						end
					end
					dup_cnt = 0;
				end else begin
					beats.push_back(b);
				end
			end
		end
		CMD_TIMEOUT: begin
			if (occ == 0) begin
				b.empty_timeout_error = 1'b1;
			end else begin
				b.packet_valid = 1'b1;
				b.packet_seq = seq_store[head];
				b.packet_data = data_store[head];
				b.timer_action = TA_RESTART;
				b.timer_seq = r.seq_field;
			end
			beats.push_back(b);
		end
		default: beats.push_back(b);
		endcase
		foreach (beats[i]) begin
			beats[i].window_full = (occ >= window_cap());
			beats[i].last = (i == beats.size() - 1);
			expected_beats.push_back(beats[i]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			occ = 0;
			base_sq = '0;
			next_sq = '0;
			dup_cnt = 0;
			limit_reg = WINDOW_LIMIT_RST;
			thresh_reg = DUP_THRESH_RST;
			err_cnt = 0;
			expected_beats.delete();
			mismatches <= 0;
			outstanding <= 0;
			base_seq_now <= '0;
			next_seq_now <= '0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_beats.size() == 0) begin
					$error("response beat with nothing expected");
					err_cnt++;
				end else begin
					want = expected_beats.pop_front();
					compare_field("accepted", want.accepted, rsp.accepted);
					compare_field("packet_valid", want.packet_valid, rsp.packet_valid);
					compare_field("packet_seq", want.packet_seq, rsp.packet_seq);
					compare_field("packet_data", want.packet_data, rsp.packet_data);
					compare_field("timer_action", want.timer_action, rsp.timer_action);
					compare_field("timer_seq", want.timer_seq, rsp.timer_seq);
					compare_field("window_full", want.window_full, rsp.window_full);
					compare_field("empty_timeout_error", want.empty_timeout_error,
						rsp.empty_timeout_error);
					compare_field("last", want.last, rsp.last);
				end
			end
			if (req_valid && req_ready)
				predict_beats(req);
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_DUP_THRESH)
					thresh_reg = pwdata[DUP_W-1:0];
				else
					limit_reg = pwdata[CFG_W-1:0];
			end
			mismatches <= err_cnt;
			outstanding <= expected_beats.size();
			base_seq_now <= base_sq;
			next_seq_now <= next_sq;
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import swsf_pkg::*;

	localparam logic [1:0]      CMD_UNUSED = 2'd3;
	localparam logic [5:0][2:0] LIMITS     = {3'd3, 3'd2, 3'd7, 3'd0, 3'd4, 3'd1};
	localparam logic [5:0][2:0] THRESHOLDS = {3'd5, 3'd3, 3'd2, 3'd0, 3'd7, 3'd1};
	localparam int              HOLD_CYCLES = 150;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;

	int               mismatches;
	int               outstanding;
	logic [SEQ_W-1:0] base_seq_now;
	logic [SEQ_W-1:0] next_seq_now;

	int               snd_idle_pct = 21;
	int               rcv_idle_pct = 80;
	int               hold_token = 0;
	int               hold_seen;
	int               hold_left;

	always #2 clk = ~clk;

	sliding_window_sender_fast_retx dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	window_sender_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.base_seq_now(base_seq_now),
		.next_seq_now(next_seq_now)
	);

	// receiver: random backpressure plus one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic offer(input logic [1:0] c, input logic [DATA_W-1:0] p,
			input logic [SEQ_W-1:0] s, input logic k);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{command: c, payload: p, seq_field: s, checksum_ok: k};
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [2:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= ($urandom() & ~32'h7) | {29'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_traffic(input int n_items);
		int               done;
		int               kind;
		int               len;
		logic [SEQ_W-1:0] span;
		logic [1:0]       c;
		logic             k;
		done = 0;
		while (done < n_items) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				len = $urandom_range(1, 5);
				repeat (len) begin
					offer(CMD_SEND, $urandom(), SEQ_W'($urandom_range(7)),
						1'($urandom_range(1)));
					done++;
				end
			end else if (kind < 55) begin
				// duplicate ack run toward fast retransmit
				len = $urandom_range(1, 8);
				repeat (len) begin
					offer(CMD_ACK, $urandom(), base_seq_now, 1'b1);
					done++;
				end
			end else if (kind < 75) begin
				span = next_seq_now - base_seq_now;
				if (span == 0)
					offer(CMD_ACK, $urandom(), SEQ_W'($urandom_range(7)), 1'b1);
				else
					offer(CMD_ACK, $urandom(),
						base_seq_now + SEQ_W'($urandom_range(1, span)), 1'b1);
				done++;
			end else if (kind < 85) begin
				offer(CMD_TIMEOUT, $urandom(),
					($urandom_range(3) == 0) ? SEQ_W'($urandom_range(7)) : base_seq_now,
					1'($urandom_range(1)));
				done++;
			end else begin
				c = 2'($urandom_range(3));
				k = 1'($urandom_range(1));
				offer(c, $urandom(), SEQ_W'($urandom_range(7)), k);
				if (!(c == CMD_UNUSED || (c == CMD_ACK && !k)))
					done++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty window: timeout error, duplicate acks up to threshold, ignored beats
		offer(CMD_TIMEOUT, '1, 3'd0, 1'b1);
		repeat (3) offer(CMD_ACK, '0, 3'd0, 1'b1);
		offer(CMD_ACK, '1, 3'd7, 1'b0);
		offer(CMD_UNUSED, '1, 3'd7, 1'b1);
		// fill the window, then one rejected send
		offer(CMD_SEND, 32'h0000_0000, 3'd0, 1'b0);
		offer(CMD_SEND, 32'hFFFF_FFFF, 3'd7, 1'b1);
		offer(CMD_SEND, 32'hA5A5_A5A5, 3'd5, 1'b0);
		offer(CMD_SEND, 32'h5A5A_5A5A, 3'd2, 1'b1);
		offer(CMD_SEND, 32'h1234_5678, 3'd0, 1'b0);
		offer(CMD_TIMEOUT, '0, 3'd7, 1'b0);
		// fast retransmit of the full window
		repeat (3) offer(CMD_ACK, '0, 3'd0, 1'b1);
		// partial pop, full pop, new ack on an empty window
		offer(CMD_ACK, '0, 3'd2, 1'b1);
		offer(CMD_ACK, '0, 3'd4, 1'b1);
		offer(CMD_ACK, '0, 3'd7, 1'b1);

		for (int p = 0; p < 6; p++) begin
			drain();
			write_reg({REG_WINDOW_LIMIT, 2'b00}, LIMITS[p]);
			write_reg({REG_DUP_THRESH, 2'b00}, THRESHOLDS[p]);
			if (p < 2) begin
				snd_idle_pct = 21;
				rcv_idle_pct <= 80;
			end else if (p < 4) begin
				snd_idle_pct = 80;
				rcv_idle_pct <= 21;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct <= 0;
			end
			run_traffic(40);
			if (p == 2)
				drain();
			if (p == 4)
				hold_token <= hold_token + 1;
			run_traffic(35);
		end
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("sliding_window_sender_fast_retx regression: pass");
		else
			$display("sliding_window_sender_fast_retx regression: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("sliding_window_sender_fast_retx regression: fail");
		$finish;
	end

endmodule
